// ===== design/sha_pkg.sv =====
// Package with SHA-256 types, constants and round functions.
package sha_pkg;

	localparam int unsigned QueueDepth = 4;

	typedef logic [31:0] word_t;

	// Input item: one message byte with its flags.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last_byte;
	} byte_item_t;

	// Result item: one digest word with its position.
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} word_item_t;

	// Command handed from the front part to the back part.
	typedef struct packed {
		logic [7:0] data;
		logic       has;
		logic       last;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_TAKE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_EMIT
	} back_state_t;

	localparam logic [7:0] PadMark = 8'h80;

	function automatic word_t initial_hash(input logic [2:0] idx);
		word_t r;
		unique case (idx)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	localparam word_t RoundConst [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t small_sig0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_sig1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t big_sig0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t big_sig1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

// ===== design/sha_stream_if.sv =====
// Valid/ready channel interface with a generic payload.
interface sha_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== design/sha_front.sv =====
// Front part: accepts input items, drops idle ones and queues the rest.
module sha_front
	import sha_pkg::*;
#(
	parameter int unsigned Depth = QueueDepth
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic q_valid,
	input  logic q_ready,
	output cmd_t q_cmd
);
	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

	cmd_t            mem_q [Depth];
	logic [AW-1:0]   wr_q, rd_q;
	logic [AW:0]     cnt_q;
	logic            push, pop, useful;

	assign useful   = in_cmd.has | in_cmd.last;
	assign in_ready = (cnt_q != (AW+1)'(Depth));
	assign push     = in_valid & in_ready & useful;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_valid & q_ready;
	assign q_cmd    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

// ===== design/sha_back.sv =====
// Back part: block store, padding, round-per-cycle compression and digest output.
module sha_back
	import sha_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	output logic        q_ready,
	input  cmd_t        q_cmd,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	back_state_t state_q, state_d;

	word_t       h_q [8];
	word_t       v_q [8];
	word_t       w_q [16];
	logic [5:0]  fill_q;
	logic [63:0] bits_q;
	logic [63:0] len_q;
	logic [5:0]  rnd_q;
	logic        fin_q;
	logic        padded_q;
	logic        pad_mark_q;
	logic [2:0]  idx_q;

	logic        put;
	logic [7:0]  put_byte;
	logic        full;
	word_t       t1, t2, wnew;

	assign full = (fill_q == 6'd63);
	assign q_ready = (state_q == ST_TAKE);
	assign out_valid = (state_q == ST_EMIT);
	assign digest_word = h_q[idx_q];
	assign word_index = idx_q;
	assign last_word = (idx_q == 3'd7);

	assign t1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ RoundConst[rnd_q] + w_q[0];
	assign t2 = big_sig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign wnew = w_q[0] + small_sig0(w_q[1]) + w_q[9] + small_sig1(w_q[14]);

	// Byte written into the store this cycle: a message byte or a padding byte.
	always_comb begin
		put = 1'b0;
		put_byte = q_cmd.data;
		if (state_q == ST_TAKE && q_valid && q_cmd.has) begin
			put = 1'b1;
		end else if (state_q == ST_PAD) begin
			put = 1'b1;
			if (!pad_mark_q) begin
				put_byte = PadMark;
			end else if (padded_q && fill_q >= 6'd56) begin
				put_byte = len_q[8'd63 - {fill_q[2:0], 3'b000} -: 8];
			end else begin
				put_byte = 8'h00;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_TAKE: begin
				if (q_valid) begin
					if (q_cmd.has && full) begin
						state_d = ST_ROUND;
					end else if (q_cmd.last) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_ROUND: begin
				if (rnd_q == 6'd63) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				if (!fin_q) begin
					state_d = ST_TAKE;
				end else if (padded_q) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (full) begin
					state_d = ST_ROUND;
				end
			end
			ST_EMIT: begin
				if (out_ready && idx_q == 3'd7) begin
					state_d = ST_TAKE;
				end
			end
			default: state_d = ST_TAKE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_TAKE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= initial_hash(3'(i));
			end
			fill_q     <= '0;
			bits_q     <= '0;
			rnd_q      <= '0;
			fin_q      <= 1'b0;
			padded_q   <= 1'b0;
			pad_mark_q <= 1'b0;
			idx_q      <= '0;
		end else begin
			if (put) begin
				fill_q <= fill_q + 1'b1;
			end
			if (state_q == ST_TAKE && q_valid) begin
				if (q_cmd.has) begin
					bits_q <= bits_q + 64'd8;
				end
				if (q_cmd.last) begin
					fin_q      <= 1'b1;
					pad_mark_q <= 1'b0;
					padded_q   <= 1'b0;
				end
			end
			if (state_q == ST_PAD) begin
				pad_mark_q <= 1'b1;
				// Length lands in this block once the fill reaches 56 here.
				if (!padded_q && fill_q == 6'd55) begin
					padded_q <= 1'b1;
				end
			end
			if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 1'b1;
			end
			if (state_q == ST_ADD) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
			end
			if (state_q == ST_EMIT && out_ready) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == 3'd7) begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= initial_hash(3'(i));
					end
					fin_q  <= 1'b0;
					bits_q <= '0;
					fill_q <= '0;
				end
			end
		end
	end

	// Payload registers: schedule window, working variables, latched length.
	always_ff @(posedge clk) begin
		if (state_q == ST_TAKE && q_valid && q_cmd.last) begin
			len_q <= bits_q + (q_cmd.has ? 64'd8 : 64'd0);
		end
		if (put) begin
			w_q[fill_q[5:2]] <= (w_q[fill_q[5:2]] << 8) | {24'd0, put_byte};
		end
		if (put && full) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end
		if (state_q == ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= wnew;
		end
	end
endmodule

// ===== design/sha256_byte_stream_hasher.sv =====
// Top level of the SHA-256 byte stream hasher.
//
//   channel | direction | payload
//   in      | sink      | data_byte[7:0], has_byte, last_byte
//   out     | source    | digest_word[31:0], word_index[2:0], last_word
//
// A message byte is registered in the queue, then shifted into the block store.
// Each full block runs 64 rounds plus one chaining add in the back part.
// A last item adds the padding bytes (one per cycle, paused for the rounds, up to
// two blocks) and then eight digest items, one per cycle while out.ready is high.
// arst_n loads the initial hash values and clears counts and queue.
// The input queue (Depth items, four by default) absorbs bytes during a compression.
module sha256_byte_stream_hasher
	import sha_pkg::*;
#(
	parameter int unsigned Depth = QueueDepth
) (
	input  logic clk,
	input  logic arst_n,
	sha_stream_if.sink   in,
	sha_stream_if.source out
);
	cmd_t in_cmd, q_cmd;
	logic q_valid, q_ready;
	logic [31:0] dw;
	logic [2:0]  wi;
	logic        lw;

	assign in_cmd.data = in.payload.data_byte;
	assign in_cmd.has  = in.payload.has_byte;
	assign in_cmd.last = in.payload.last_byte;

	sha_front #(.Depth(Depth)) u_front (
		.clk, .arst_n,
		.in_valid(in.valid), .in_ready(in.ready), .in_cmd,
		.q_valid, .q_ready, .q_cmd
	);

	sha_back u_back (
		.clk, .arst_n,
		.q_valid, .q_ready, .q_cmd,
		.out_valid(out.valid), .out_ready(out.ready),
		.digest_word(dw), .word_index(wi), .last_word(lw)
	);

	assign out.payload.digest_word = dw;
	assign out.payload.word_index  = wi;
	assign out.payload.last_word   = lw;

	// Digest words come out in order.
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.ready && !lw |=> out.valid && wi == $past(wi) + 3'd1)
		else $error("digest word index skipped");

	// The back part never takes queue items while emitting.
	a_no_take_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> !q_ready)
		else $error("queue read during digest output");

	// A held digest word keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> $stable(dw))
		else $error("digest word changed under stall");
endmodule
